/* rtl/core/hct_pkg.sv */
// Shared types and constants for the heap canary table.
`default_nettype none

package hct_pkg;

   // opcode field encodings
   localparam logic [1:0] OPC_ADD    = 2'd0;
   localparam logic [1:0] OPC_REMOVE = 2'd1;
   localparam logic [1:0] OPC_VERIFY = 2'd2;

   // status field encodings
   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_FULL      = 2'd1;
   localparam logic [1:0] STS_NOT_FOUND = 2'd2;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      K_ADD    = 2'd0,
      K_REMOVE = 2'd1,
      K_VERIFY = 2'd2,
      K_NONE   = 2'd3
   } op_kind_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [63:0] block_address;
      logic [3:0]  slot_select;
      logic [63:0] observed_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  slot_index;
      logic        slot_valid;
      logic [31:0] expected_canary;
      logic [63:0] stored_address;
      logic        overflow_detected;
   } rsp_type;

   // decoded command as it sits in the queue
   typedef struct packed {
      op_kind_type kind;
      logic        sel_ok;
      logic [3:0]  slot_select;
      logic [63:0] block_address;
      logic [63:0] observed_value;
   } cmd_type;

endpackage

`default_nettype wire

/* rtl/core/hct_front.sv */
// Input stage: takes request words, decodes them and feeds the command queue.
`default_nettype none

module hct_front import hct_pkg::*; #(
   parameter int SLOT_COUNT = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    push_valid,
   input  logic    push_ready,
   output cmd_type push_cmd
);

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   cmd_type dec;

   always_comb begin
      dec                = '0;
      dec.block_address  = req_payload.block_address;
      dec.slot_select    = req_payload.slot_select;
      dec.observed_value = req_payload.observed_value;
      dec.sel_ok         = (int'(req_payload.slot_select) < SLOT_COUNT);
      case (req_payload.opcode)
         OPC_ADD:    dec.kind = K_ADD;
         OPC_REMOVE: dec.kind = K_REMOVE;
         OPC_VERIFY: dec.kind = K_VERIFY;
         default:    dec.kind = K_NONE;
      endcase
   end

   assign req_ready  = !valid_ff || push_ready;
   assign push_valid = valid_ff;
   assign push_cmd   = cmd_ff;

   always_comb begin
      valid_in = valid_ff;
      cmd_in   = cmd_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         cmd_in   = dec;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

`default_nettype wire

/* rtl/core/hct_queue.sv */
// Short command queue decoupling the decode stage from the table engine.
`default_nettype none

module hct_queue import hct_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop,
   output cmd_type pop_cmd
);

   cmd_type            slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wptr_ff, wptr_in;
   logic [QPTR_W-1:0]  rptr_ff, rptr_in;
   logic [QPTR_W:0]    count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != (QPTR_W + 1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slots_ff[rptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wptr_in  = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop  ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         slots_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/hct_back.sv */
// Table engine: slot storage, free/match scan, update and result register.
`default_nettype none

module hct_back import hct_pkg::*; #(
   parameter int SLOT_COUNT = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_pop,
   input  cmd_type cmd,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_EXEC = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   cmd_type                 cur_ff, cur_in;
   logic [SLOT_COUNT-1:0]   valid_ff, valid_in;
   logic [SLOT_COUNT-1:0]   match_ff, match_in;
   logic [31:0]             counter_ff, counter_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;
   logic [31:0]             canary_ff [SLOT_COUNT];
   logic [63:0]             addr_ff [SLOT_COUNT];

   logic [SLOT_COUNT-1:0]   scan_vec;
   logic                    hit;
   logic [IDX_W-1:0]        enc_idx, vidx, ridx;
   logic [31:0]             rd_canary, counter_inc;
   logic [63:0]             rd_addr;
   logic                    fire, wr_en;
   logic [31:0]             canary_in;
   logic [63:0]             addr_in;
   rsp_type                 res;

   // per-slot address compare, registered for the execute cycle
   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         match_in[i] = valid_ff[i] && (addr_ff[i] == cur_ff.block_address);
      end
   end

   // lowest free slot for add, lowest live match for remove
   always_comb begin
      scan_vec = (cur_ff.kind == K_ADD) ? ~valid_ff : match_ff;
      hit      = 1'b0;
      enc_idx  = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (scan_vec[i]) begin
            hit     = 1'b1;
            enc_idx = IDX_W'(i);
         end
      end
   end

   assign vidx      = IDX_W'(cur_ff.slot_select);
   assign ridx      = (cur_ff.kind == K_VERIFY) ? vidx : enc_idx;
   assign rd_canary = canary_ff[ridx];
   assign rd_addr   = addr_ff[ridx];

   assign counter_inc = counter_ff + 32'd1;
   assign fire        = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign cmd_pop     = cmd_valid && ((state_ff == S_IDLE) || fire);
   assign canary_in   = counter_inc;
   assign addr_in     = cur_ff.block_address;
   assign wr_en       = fire && (cur_ff.kind == K_ADD) && hit;

   always_comb begin
      res        = '0;
      valid_in   = valid_ff;
      counter_in = counter_ff;
      case (cur_ff.kind)
         K_ADD: begin
            if (fire) begin
               counter_in = counter_inc;
            end
            if (hit) begin
               res.slot_index      = 4'(enc_idx);
               res.expected_canary = counter_inc;
               if (fire) begin
                  valid_in[enc_idx] = 1'b1;
               end
            end else begin
               res.status = STS_FULL;
            end
         end
         K_REMOVE: begin
            if (hit) begin
               res.slot_index      = 4'(enc_idx);
               res.expected_canary = rd_canary;
               if (fire) begin
                  valid_in[enc_idx] = 1'b0;
               end
            end else begin
               res.status = STS_NOT_FOUND;
            end
         end
         K_VERIFY: begin
            res.slot_index = cur_ff.slot_select;
            if (cur_ff.sel_ok && valid_ff[vidx]) begin
               res.slot_valid        = 1'b1;
               res.expected_canary   = rd_canary;
               res.stored_address    = rd_addr;
               res.overflow_detected = (cur_ff.observed_value != {32'd0, rd_canary});
            end
         end
         default: begin
            res = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd_pop) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: state_in = S_EXEC;
         S_EXEC: begin
            if (fire) begin
               state_in = cmd_pop ? S_SCAN : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cur_in       = cmd_pop ? cmd : cur_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff   <= cur_in;
      match_ff <= match_in;
      rsp_ff   <= rsp_in;
      if (wr_en) begin
         canary_ff[enc_idx] <= canary_in;
         addr_ff[enc_idx]   <= addr_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

/* rtl/core/heap_canary_table.sv */
// Heap canary table: guard-value slot table with add, remove and verify.
//
// Request channel (req_valid/req_ready/req_payload) takes one command word:
// add an address (a new canary is drawn from a running counter), remove an
// address, or verify a slot against the value now read at its address.
// Response channel (rsp_valid/rsp_ready/rsp_payload) returns exactly one
// word per command, in command order.
// A decode stage feeds a two-entry command queue; the table engine takes
// each command through a scan state that compares every slot's address in
// parallel, then an execute state that picks the lowest free or matching
// slot (the selected slot for verify) and updates the table. The engine
// pops the next queued command, if any, as it finishes the current one.
// When rsp_ready is low the response register holds its word, the engine
// stops in its execute cycle and the queue and decode stage fill, after
// which req_ready drops.
// Reset (synchronous, active high) frees every slot, zeroes the canary
// counter and empties queue and response register; slot contents are not
// cleared.
`default_nettype none

module heap_canary_table import hct_pkg::*; #(
   parameter int SLOT_COUNT = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic    push_valid, push_ready;
   cmd_type push_cmd;
   logic    q_valid, q_pop;
   cmd_type q_cmd;

   hct_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_cmd    (push_cmd)
   );

   hct_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_cmd    (q_cmd)
   );

   hct_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (q_valid),
      .cmd_pop     (q_pop),
      .cmd         (q_cmd),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // engine never pulls from an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("command popped from empty queue");

   // a decoded word stalled at the queue is held intact
   a_push_hold: assert property (@(posedge clock) disable iff (reset)
      (push_valid && !push_ready) |=> (push_valid && $stable(push_cmd)))
      else $error("decoded word lost while queue full");

   // a full queue with a pending decoded word must stall the request side
   a_front_stall: assert property (@(posedge clock) disable iff (reset)
      (push_valid && !push_ready) |-> !req_ready)
      else $error("request accepted with no room downstream");

   // no response survives reset
   a_reset_rsp: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

`default_nettype wire

/* tb/tb_heap_canary_table.sv */
// Self-checking testbench for the heap canary table: directed rows, then random words.
`timescale 1ns / 1ps

module tb_heap_canary_table;
   import hct_pkg::*;

   localparam int SLOTS = 16;
   localparam int POOL_N = 24;
   localparam int RAND_ITEMS = 1380;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 16;
   localparam logic [1:0] OPC_UNUSED = 2'd3;

   typedef struct {
      req_type word;
      int      copies;   // repeated with the address stepped by one each time
      bit      typed;
      rsp_type want;
   } plan_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   // sideband that travels with the request word
   logic    want_typed;
   rsp_type typed_rsp;

   // predictor copy of the slot table
   bit          live [SLOTS];
   logic [31:0] canary_of [SLOTS];
   logic [63:0] address_of [SLOTS];
   logic [31:0] canary_count;

   rsp_type      due_rsp_q [$];
   rsp_type      predicted;
   rsp_type      oldest;
   logic [63:0]  addr_pool [POOL_N];
   plan_row_type plan [$];
   int           errors;
   int           quiet_cycles;
   int           send_idle_pct;
   int           recv_idle_pct;

   heap_canary_table u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic rsp_type table_step(req_type w);
      rsp_type r;
      bit      done;
      r = '0;
      done = 1'b0;
      case (w.opcode)
         OPC_ADD: begin
            canary_count = canary_count + 32'd1;
            r.status = STS_FULL;
            for (int s = 0; s < SLOTS; s++) begin
               if (!done && !live[s]) begin
                  live[s] = 1'b1;
                  canary_of[s] = canary_count;
                  address_of[s] = w.block_address;
                  r.status = STS_OK;
                  r.slot_index = 4'(s);
                  r.expected_canary = canary_count;
                  done = 1'b1;
               end
            end
         end
         OPC_REMOVE: begin
            r.status = STS_NOT_FOUND;
            for (int s = 0; s < SLOTS; s++) begin
               if (!done && live[s] && address_of[s] == w.block_address) begin
                  live[s] = 1'b0;
                  r.status = STS_OK;
                  r.slot_index = 4'(s);
                  r.expected_canary = canary_of[s];
                  done = 1'b1;
               end
            end
         end
         OPC_VERIFY: begin
            r.slot_index = w.slot_select;
            if (live[w.slot_select]) begin
               r.slot_valid = 1'b1;
               r.expected_canary = canary_of[w.slot_select];
               r.stored_address = address_of[w.slot_select];
               r.overflow_detected = (w.observed_value != {32'h0, canary_of[w.slot_select]});
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic plan_row_type row(logic [1:0] op, logic [63:0] addr, logic [3:0] sel,
                                        logic [63:0] obs, int copies, bit typed, rsp_type want);
      plan_row_type p;
      p.word = '{opcode: op, block_address: addr, slot_select: sel, observed_value: obs};
      p.copies = copies;
      p.typed = typed;
      p.want = want;
      return p;
   endfunction

   task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
      end
   endtask

   task automatic send_word(req_type w, bit typed, rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= w;
      want_typed <= typed;
      typed_rsp <= want;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   // hold off until every outstanding response has drained
   task automatic drain_pause();
      req_valid <= 1'b0;
      do @(posedge clock); while (due_rsp_q.size() != 0);
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         predicted = table_step(req_payload);
         due_rsp_q.push_back(want_typed ? typed_rsp : predicted);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_rsp_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected response word, expected none actual %h",
                     $time, rsp_payload);
         end else begin
            oldest = due_rsp_q.pop_front();
            check_field("status", 64'(oldest.status), 64'(rsp_payload.status));
            check_field("slot_index", 64'(oldest.slot_index), 64'(rsp_payload.slot_index));
            check_field("slot_valid", 64'(oldest.slot_valid), 64'(rsp_payload.slot_valid));
            check_field("expected_canary", 64'(oldest.expected_canary),
                        64'(rsp_payload.expected_canary));
            check_field("stored_address", oldest.stored_address, rsp_payload.stored_address);
            check_field("overflow_detected", 64'(oldest.overflow_detected),
                        64'(rsp_payload.overflow_detected));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      req_type w;
      int      roll;
      int      pick;
      int      occ;
      int      add_w;
      int      rem_w;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      want_typed = 1'b0;
      typed_rsp = '0;
      errors = 0;
      quiet_cycles = 0;
      canary_count = '0;
      send_idle_pct = 7;
      recv_idle_pct = 60;
      for (int s = 0; s < SLOTS; s++) begin
         live[s] = 1'b0;
         canary_of[s] = '0;
         address_of[s] = '0;
      end
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (int k = 2; k < POOL_N; k++) addr_pool[k] = {$urandom, $urandom};

      // remove on an empty table, unused opcode, fill, full, duplicates, free-slot verify
      plan.push_back(row(OPC_REMOVE, '0, '0, '0, 1, 1'b1,
                         '{STS_NOT_FOUND, 4'd0, 1'b0, 32'd0, 64'd0, 1'b0}));
      plan.push_back(row(OPC_UNUSED, '1, 4'hF, '1, 1, 1'b1,
                         '{STS_OK, 4'd0, 1'b0, 32'd0, 64'd0, 1'b0}));
      plan.push_back(row(OPC_ADD, '0, '0, '0, 1, 1'b1,
                         '{STS_OK, 4'd0, 1'b0, 32'd1, 64'd0, 1'b0}));
      plan.push_back(row(OPC_VERIFY, '0, 4'd0, 64'd1, 1, 1'b1,
                         '{STS_OK, 4'd0, 1'b1, 32'd1, 64'd0, 1'b0}));
      // upper half of the observed word must take part in the compare
      plan.push_back(row(OPC_VERIFY, '0, 4'd0, 64'h1_0000_0001, 1, 1'b1,
                         '{STS_OK, 4'd0, 1'b1, 32'd1, 64'd0, 1'b1}));
      plan.push_back(row(OPC_ADD, '1, '0, '0, 1, 1'b1,
                         '{STS_OK, 4'd1, 1'b0, 32'd2, 64'd0, 1'b0}));
      plan.push_back(row(OPC_ADD, '0, '0, '0, 1, 1'b1,
                         '{STS_OK, 4'd2, 1'b0, 32'd3, 64'd0, 1'b0}));
      plan.push_back(row(OPC_ADD, 64'hA5A5_A5A5_5A5A_5A5A, '0, '0, 13, 1'b0, '0));
      plan.push_back(row(OPC_ADD, 64'd5, '0, '0, 1, 1'b1,
                         '{STS_FULL, 4'd0, 1'b0, 32'd0, 64'd0, 1'b0}));
      plan.push_back(row(OPC_REMOVE, '0, '0, '0, 1, 1'b1,
                         '{STS_OK, 4'd0, 1'b0, 32'd1, 64'd0, 1'b0}));
      plan.push_back(row(OPC_VERIFY, '0, 4'd0, '1, 1, 1'b1,
                         '{STS_OK, 4'd0, 1'b0, 32'd0, 64'd0, 1'b0}));
      plan.push_back(row(OPC_REMOVE, '0, '0, '0, 1, 1'b1,
                         '{STS_OK, 4'd2, 1'b0, 32'd3, 64'd0, 1'b0}));
      plan.push_back(row(OPC_REMOVE, '0, '0, '0, 1, 1'b1,
                         '{STS_NOT_FOUND, 4'd0, 1'b0, 32'd0, 64'd0, 1'b0}));
      plan.push_back(row(OPC_ADD, 64'h8000_0000_0000_0000, '0, '0, 1, 1'b0, '0));
      plan.push_back(row(OPC_VERIFY, '0, 4'd15, 64'd16, 1, 1'b0, '0));
      plan.push_back(row(OPC_VERIFY, '0, 4'd15, '1, 1, 1'b0, '0));
      plan.push_back(row(OPC_VERIFY, '1, 4'd2, 64'd3, 1, 1'b0, '0));
      plan.push_back(row(OPC_REMOVE, '1, '0, '0, 1, 1'b1,
                         '{STS_OK, 4'd1, 1'b0, 32'd2, 64'd0, 1'b0}));
      plan.push_back(row(OPC_UNUSED, '0, '0, '0, 1, 1'b1,
                         '{STS_OK, 4'd0, 1'b0, 32'd0, 64'd0, 1'b0}));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         for (int k = 0; k < plan[r].copies; k++) begin
            w = plan[r].word;
            w.block_address = w.block_address + 64'(k);
            send_word(w, plan[r].typed, plan[r].want);
         end
      end
      drain_pause();

      for (int i = 0; i < RAND_ITEMS; i++) begin
         if (i == RAND_ITEMS / 3) begin
            drain_pause();
            send_idle_pct = 60;
            recv_idle_pct = 7;
         end else if (i == 2 * RAND_ITEMS / 3) begin
            drain_pause();
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         occ = 0;
         for (int s = 0; s < SLOTS; s++) occ += live[s];
         // every third stretch of 100 words leans on adds so the table fills up
         if ((i / 100) % 3 == 1) begin
            add_w = 60;
            rem_w = 15;
         end else begin
            add_w = (occ < 8) ? 45 : 25;
            rem_w = 30;
         end
         w.block_address = {$urandom, $urandom};
         w.slot_select = 4'($urandom_range(15));
         w.observed_value = {$urandom, $urandom};
         roll = $urandom_range(99);
         pick = $urandom_range(99);
         if (roll < 3) begin
            w.opcode = OPC_UNUSED;
         end else if (roll < 3 + add_w) begin
            w.opcode = OPC_ADD;
            if (pick < 85) w.block_address = addr_pool[$urandom_range(POOL_N - 1)];
         end else if (roll < 3 + add_w + rem_w) begin
            w.opcode = OPC_REMOVE;
            if (pick < 85) w.block_address = addr_pool[$urandom_range(POOL_N - 1)];
         end else begin
            w.opcode = OPC_VERIFY;
            if (pick < 50)
               w.observed_value = {32'h0, canary_of[w.slot_select]};
            else if (pick < 75)
               w.observed_value = {32'h0, canary_of[w.slot_select]} ^
                                  (64'h1 << $urandom_range(63));
         end
         send_word(w, 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (due_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/hct_pkg.sv
rtl/core/hct_front.sv
rtl/core/hct_queue.sv
rtl/core/hct_back.sv
rtl/core/heap_canary_table.sv
tb/tb_heap_canary_table.sv
